>>> design/lspwq_pkg.sv
// shared types and constants for the log-step parity watermark quantizer
package lspwq_pkg;

  localparam int unsigned XW     = 36;
  localparam int unsigned HW     = 18;
  localparam int unsigned PW     = 2 * HW;
  localparam int unsigned SUMW   = XW + HW;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 18;

  localparam logic [31:0]     ONE_Q16  = 32'h0001_0000;
  localparam logic [SUMW-1:0] ROUND    = SUMW'(32768);
  localparam logic [31:0]     SAT_POS  = 32'h7FFF_FFFF;
  localparam logic [31:0]     SAT_NEG  = 32'h8000_0000;

  localparam logic [17:0] FWD_RESET = 18'd80099;
  localparam logic [15:0] BWD_RESET = 16'd53620;

  localparam logic [CFG_IW-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IW-1:0] REG_BIT_COUNT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_FORWARD   = 2'd2;
  localparam logic [CFG_IW-1:0] REG_BACKWARD  = 2'd3;

  localparam logic MODE_EMBED  = 1'b0;
  localparam logic MODE_DETECT = 1'b1;
  localparam logic KIND_SIG    = 1'b0;
  localparam logic KIND_COEFF  = 1'b1;

  typedef struct packed {
    logic sig_write;
    logic load;
    logic check;
    logic mul_lo;
    logic mul_hi;
    logic mul_sum;
    logic mul_to_xb;
    logic step_inc;
    logic decide;
    logic copy_x;
    logic mid;
    logic finish;
  } lspwq_cmd_t;

  typedef struct packed {
    logic active;
    logic climb_more;
    logic mode;
    logic det_ne_want;
    logic up_nearer;
    logic out_free;
  } lspwq_status_t;

endpackage

>>> design/lspwq_in_if.sv
// input item channel
interface lspwq_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [4:0]         sig_index;
  logic [31:0]        sig_word;
  logic signed [31:0] coeff;
  logic               last;

  modport source (output valid, kind, sig_index, sig_word, coeff, last, input ready);
  modport sink (input valid, kind, sig_index, sig_word, coeff, last, output ready);
endinterface

>>> design/lspwq_out_if.sv
// result item channel
interface lspwq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coeff_out;
  logic               bit_used;
  logic               detected_bit;
  logic signed [11:0] agree_sum;
  logic [10:0]        bits_done;
  logic               last_out;

  modport source (output valid, coeff_out, bit_used, detected_bit, agree_sum, bits_done,
                  last_out, input ready);
  modport sink (input valid, coeff_out, bit_used, detected_bit, agree_sum, bits_done,
                last_out, output ready);
endinterface

>>> design/lspwq_cfg_if.sv
// configuration write channel
interface lspwq_cfg_if import lspwq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/lspwq_ram.sv
// generic single-write, single-read ram with registered read
module lspwq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/lspwq_dp.sv
// datapath: config registers, signature store, ladder multiplier, counters, result register
module lspwq_dp import lspwq_pkg::*; #(
  parameter int unsigned MAX_SIG_BITS = 1024,
  parameter int unsigned MAX_STEPS    = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  lspwq_cmd_t         cmd,
  output lspwq_status_t      status,
  input  logic [4:0]         sig_index,
  input  logic [31:0]        sig_word,
  input  logic signed [31:0] coeff,
  input  logic               last,
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] coeff_out,
  output logic               bit_used,
  output logic               detected_bit,
  output logic signed [11:0] agree_sum,
  output logic [10:0]        bits_done,
  output logic               last_out
);

  localparam int unsigned WORDS = MAX_SIG_BITS / 32;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CW    = $clog2(MAX_SIG_BITS + 1);
  localparam int unsigned LW    = (CW > 11) ? CW : 11;
  localparam int unsigned SW    = $clog2(MAX_STEPS + 1);

  logic              mode;
  logic [10:0]       bit_count;
  logic [17:0]       fwd;
  logic [15:0]       bwd;

  logic [CW-1:0]     counter;
  logic signed [11:0] acc;

  logic signed [31:0] raw;
  logic [31:0]       mag;
  logic              neg;
  logic              last_r;
  logic [XW-1:0]     x;
  logic [XW-1:0]     xb;
  logic [SW-1:0]     steps;
  logic              used;
  logic              det;
  logic [PW-1:0]     prod_lo;
  logic [PW-1:0]     prod_hi;
  logic [31:0]       mid_out;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_EMBED;
      bit_count <= '0;
      fwd       <= FWD_RESET;
      bwd       <= BWD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:      mode      <= cfg_data[0];
        REG_BIT_COUNT: bit_count <= cfg_data[10:0];
        REG_FORWARD:   fwd       <= cfg_data[17:0];
        REG_BACKWARD:  bwd       <= cfg_data[15:0];
      endcase
    end
  end

  // signature store
  logic [AW+4:0]   idx_ext;
  logic            sig_we;
  logic [CW+AW-1:0] word_ext;
  logic [31:0]     sig_rdata;
  logic            want;

  assign idx_ext  = (AW + 5)'(sig_index);
  assign sig_we   = cmd.sig_write && (idx_ext < (AW + 5)'(WORDS));
  assign word_ext = (CW + AW)'(counter) >> 5;

  lspwq_ram #(.WIDTH(32), .DEPTH(WORDS)) u_sig_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata (sig_word),
    .raddr (word_ext[AW-1:0]),
    .rdata (sig_rdata)
  );

  assign want = sig_rdata[counter[4:0]];

  // bit limit
  logic [LW-1:0] cnt_ext;
  logic [LW-1:0] bc_ext;
  logic [LW-1:0] lim;
  logic          below;

  assign cnt_ext = LW'(counter);
  assign bc_ext  = LW'(bit_count);
  assign lim     = (bc_ext < LW'(MAX_SIG_BITS)) ? bc_ext : LW'(MAX_SIG_BITS);
  assign below   = cnt_ext < lim;

  // input magnitude
  logic [31:0] coeff_u;
  logic [31:0] mag_in;

  assign coeff_u = coeff;
  assign mag_in  = coeff_u[31] ? (~coeff_u + 32'd1) : coeff_u;

  // ratio multiplier, one half of x per cycle
  logic [HW-1:0]   ratio;
  logic [HW-1:0]   mul_in;
  logic [PW-1:0]   mul_p;
  logic [SUMW-1:0] mul_sum;
  logic [XW-1:0]   mul_res;

  assign ratio   = cmd.mul_to_xb ? HW'(bwd) : fwd;
  assign mul_in  = cmd.mul_hi ? x[XW-1:HW] : x[HW-1:0];
  assign mul_p   = PW'(mul_in) * PW'(ratio);
  assign mul_sum = {prod_hi, HW'(0)} + SUMW'(prod_lo) + ROUND;
  assign mul_res = mul_sum[XW+15:16];

  // distances for the parity fix
  logic [XW-1:0] mag_ext;
  logic [XW-1:0] d_up;
  logic [XW-1:0] d_dn;

  assign mag_ext = XW'(mag);
  assign d_up    = (x > mag_ext) ? (x - mag_ext) : (mag_ext - x);
  assign d_dn    = (xb > mag_ext) ? (xb - mag_ext) : (mag_ext - xb);

  // midpoint
  logic [XW:0]   mid_sum;
  logic [XW-1:0] mid;
  logic [31:0]   mid_sat;

  assign mid_sum = (XW + 1)'(x) + (XW + 1)'(xb);
  assign mid     = mid_sum[XW:1];

  always_comb begin
    if (neg) begin
      mid_sat = (mid > XW'(SAT_NEG)) ? SAT_NEG : mid[31:0];
    end else begin
      mid_sat = (mid > XW'(SAT_POS)) ? SAT_POS : mid[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw    <= coeff;
      mag    <= mag_in;
      neg    <= coeff_u[31];
      last_r <= last;
      x      <= XW'(ONE_Q16);
      steps  <= '0;
      det    <= 1'b0;
      used   <= 1'b0;
    end
    if (cmd.check) begin
      used <= status.active;
    end
    if (cmd.mul_lo) begin
      prod_lo <= mul_p;
    end
    if (cmd.mul_hi) begin
      prod_hi <= mul_p;
    end
    if (cmd.mul_sum) begin
      if (cmd.mul_to_xb) begin
        xb <= mul_res;
      end else begin
        x <= mul_res;
      end
      if (cmd.step_inc) begin
        steps <= steps + SW'(1);
      end
    end
    if (cmd.copy_x) begin
      x <= xb;
    end
    if (cmd.decide) begin
      det <= ~steps[0];
    end
    if (cmd.mid) begin
      mid_out <= neg ? (~mid_sat + 32'd1) : mid_sat;
    end
  end

  // counters and result register
  logic [CW-1:0]      cnt_new;
  logic [LW-1:0]      cnt_new_ext;
  logic signed [11:0] acc_new;

  assign cnt_new     = used ? (counter + CW'(1)) : counter;
  assign cnt_new_ext = LW'(cnt_new);

  always_comb begin
    acc_new = acc;
    if (used && (mode == MODE_DETECT)) begin
      if (det ^ want) begin
        acc_new = (acc == -12'sd2048) ? acc : (acc - 12'sd1);
      end else begin
        acc_new = (acc == 12'sd2047) ? acc : (acc + 12'sd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter   <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        counter   <= last_r ? '0 : cnt_new;
        acc       <= last_r ? '0 : acc_new;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      coeff_out    <= (used && (mode == MODE_EMBED)) ? $signed(mid_out) : raw;
      bit_used     <= used;
      detected_bit <= det;
      agree_sum    <= acc_new;
      bits_done    <= cnt_new_ext[10:0];
      last_out     <= last_r;
    end
  end

  assign status.active      = below && (mag > ONE_Q16);
  assign status.climb_more  = (mag_ext > x) && (steps < SW'(MAX_STEPS));
  assign status.mode        = mode;
  assign status.det_ne_want = det ^ want;
  assign status.up_nearer   = d_up < d_dn;
  assign status.out_free    = !out_valid || out_ready;

endmodule

>>> design/lspwq_ctrl.sv
// controller: sequences the ladder climb, parity fix, midpoint and result handoff
module lspwq_ctrl import lspwq_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  input  lspwq_status_t status,
  output lspwq_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_CLIMB   = 4'd2;
  localparam logic [3:0] S_DECIDE  = 4'd3;
  localparam logic [3:0] S_FIX     = 4'd4;
  localparam logic [3:0] S_REFIX   = 4'd5;
  localparam logic [3:0] S_MID     = 4'd6;
  localparam logic [3:0] S_FINISH  = 4'd7;
  localparam logic [3:0] S_MUL_LO  = 4'd8;
  localparam logic [3:0] S_MUL_HI  = 4'd9;
  localparam logic [3:0] S_MUL_SUM = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] ret;
  logic [3:0] ret_next;
  logic       to_xb;
  logic       to_xb_next;
  logic       climbing;
  logic       climbing_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    ret_next      = ret;
    to_xb_next    = to_xb;
    climbing_next = climbing;
    cmd           = '0;
    cmd.mul_to_xb = to_xb;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_COEFF) begin
            cmd.load   = 1'b1;
            state_next = S_CHECK;
          end else begin
            cmd.sig_write = 1'b1;
          end
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.active ? S_CLIMB : S_FINISH;
      end
      S_CLIMB: begin
        if (status.climb_more) begin
          to_xb_next    = 1'b0;
          climbing_next = 1'b1;
          ret_next      = S_CLIMB;
          state_next    = S_MUL_LO;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide    = 1'b1;
        climbing_next = 1'b0;
        if (status.mode == MODE_DETECT) begin
          state_next = S_FINISH;
        end else begin
          to_xb_next = 1'b1;
          ret_next   = S_FIX;
          state_next = S_MUL_LO;
        end
      end
      S_FIX: begin
        if (!status.det_ne_want) begin
          state_next = S_MID;
        end else if (status.up_nearer) begin
          to_xb_next = 1'b0;
          ret_next   = S_REFIX;
          state_next = S_MUL_LO;
        end else begin
          cmd.copy_x = 1'b1;
          to_xb_next = 1'b1;
          ret_next   = S_MID;
          state_next = S_MUL_LO;
        end
      end
      S_REFIX: begin
        to_xb_next = 1'b1;
        ret_next   = S_MID;
        state_next = S_MUL_LO;
      end
      S_MID: begin
        cmd.mid    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MUL_SUM;
      end
      S_MUL_SUM: begin
        cmd.mul_sum  = 1'b1;
        cmd.step_inc = climbing;
        state_next   = ret;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      to_xb    <= 1'b0;
      climbing <= 1'b0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      to_xb    <= to_xb_next;
      climbing <= climbing_next;
    end
  end

endmodule

>>> design/log_step_parity_watermark_quantizer_core.sv
// top level of the log-step parity watermark quantizer
// a signature load is written in the idle state; a skipped or spent coefficient passes idle, check and finish
// detect finishes after the climb and decide; embed adds the parity fix and midpoint; ladder steps <= MAX_STEPS
// each ladder step is one check plus a low-half, high-half and sum multiply through the shared 18x18 multiplier
// the result register lets the next request enter while a result waits to be taken
// synchronous reset clears config registers, counters, result valid and control; the signature store is unset
module log_step_parity_watermark_quantizer_core import lspwq_pkg::*; #(
  parameter int unsigned MAX_SIG_BITS = 1024,
  parameter int unsigned MAX_STEPS    = 64
) (
  input logic           clk,
  input logic           rst,
  lspwq_in_if.sink      items,
  lspwq_out_if.source   results,
  lspwq_cfg_if.sink     cfg
);

  lspwq_cmd_t    cmd;
  lspwq_status_t status;

  assign cfg.ready = 1'b1;

  lspwq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_kind  (items.kind),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lspwq_dp #(
    .MAX_SIG_BITS (MAX_SIG_BITS),
    .MAX_STEPS    (MAX_STEPS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sig_index    (items.sig_index),
    .sig_word     (items.sig_word),
    .coeff        (items.coeff),
    .last         (items.last),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .coeff_out    (results.coeff_out),
    .bit_used     (results.bit_used),
    .detected_bit (results.detected_bit),
    .agree_sum    (results.agree_sum),
    .bits_done    (results.bits_done),
    .last_out     (results.last_out)
  );

endmodule

>>> design/lspwq_checker.sv
// port-level checker for the quantizer core, bound to the top level
module lspwq_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic signed [31:0] coeff_out,
  input logic               bit_used,
  input logic               detected_bit,
  input logic [10:0]        bits_done,
  input logic               last_out
);

  logic after_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      after_last <= 1'b1;
    end else if (res_valid && res_ready) begin
      after_last <= last_out;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(coeff_out) && $stable(bits_done))
    else $error("result request changed while stalled");

  a_det_used: assert property (@(posedge clk) disable iff (rst)
    res_valid && !bit_used |-> !detected_bit)
    else $error("detected bit set on a coefficient that carried no bit");

  a_used_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && bit_used |-> bits_done != 11'd0)
    else $error("bit used but bit count is zero");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && after_last |-> bits_done == {10'd0, bit_used})
    else $error("bit count not cleared at frame start");

endmodule

bind log_step_parity_watermark_quantizer_core lspwq_checker u_lspwq_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .coeff_out    (results.coeff_out),
  .bit_used     (results.bit_used),
  .detected_bit (results.detected_bit),
  .bits_done    (results.bits_done),
  .last_out     (results.last_out)
);

>>> tb/tb.sv
// testbench for the log-step parity watermark quantizer core: scoreboard, driver and monitor
`timescale 1ns / 1ps

module tb;
  import lspwq_pkg::*;

  localparam int unsigned SIG_BITS_MAX = 1024;
  localparam int unsigned STEP_LIMIT   = 64;
  localparam int unsigned SIG_WORDS    = SIG_BITS_MAX / 32;
  localparam int unsigned HOLD_AFTER   = 700;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned PHASE_REQS   = 112;

  typedef struct {
    logic        kind;
    logic [4:0]  sig_index;
    logic [31:0] sig_word;
    logic [31:0] coeff;
    logic        last;
  } wm_request_t;

  typedef struct {
    logic [31:0] coeff_out;
    logic        bit_used;
    logic        detected_bit;
    logic [11:0] agree_sum;
    logic [10:0] bits_done;
    logic        last_out;
  } wm_result_t;

  logic clk;
  logic rst;

  lspwq_in_if  coeff_ch ();
  lspwq_out_if out_ch ();
  lspwq_cfg_if cfg_ch ();

  log_step_parity_watermark_quantizer_core DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (coeff_ch),
    .results (out_ch),
    .cfg     (cfg_ch)
  );

  wm_request_t pending_reqs[$];
  wm_result_t  expected_results[$];

  logic [31:0] sig_words [SIG_WORDS];
  logic [10:0] bits_taken;
  int          agree_acc;
  logic        cur_mode;
  logic [10:0] cur_bit_count;
  logic [17:0] cur_fwd;
  logic [15:0] cur_bwd;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned reqs_taken;
  int unsigned hold_count;
  logic        sink_hold;
  logic        hold_done;
  int unsigned error_count;

  function automatic logic [63:0] ratio_step(input logic [63:0] x, input logic [17:0] r);
    return (x * {46'd0, r} + 64'd32768) >> 16;
  endfunction

  task automatic predict_request(input wm_request_t req);
    wm_result_t  res;
    logic        neg;
    logic        want;
    logic [63:0] mag;
    logic [63:0] x;
    logic [63:0] x_down;
    logic [63:0] d_up;
    logic [63:0] d_dn;
    logic [63:0] mid;
    logic [10:0] limit;
    int unsigned steps;
    if (req.kind == KIND_SIG) begin
      sig_words[req.sig_index] = req.sig_word;
      return;
    end
    neg = req.coeff[31];
    mag = neg ? {32'd0, -req.coeff} : {32'd0, req.coeff};
    res.coeff_out = req.coeff;
    res.bit_used = 1'b0;
    res.detected_bit = 1'b0;
    limit = (cur_bit_count < SIG_BITS_MAX) ? cur_bit_count : 11'(SIG_BITS_MAX);
    if (bits_taken < limit && mag > 64'(ONE_Q16)) begin
      x = 64'(ONE_Q16);
      steps = 0;
      while (x < mag && steps < STEP_LIMIT) begin
        x = ratio_step(x, cur_fwd);
        steps++;
      end
      res.detected_bit = ~steps[0];
      want = sig_words[bits_taken[9:5]][bits_taken[4:0]];
      res.bit_used = 1'b1;
      if (cur_mode == MODE_EMBED) begin
        if (res.detected_bit != want) begin
          x_down = ratio_step(x, {2'b00, cur_bwd});
          d_up = (mag > x) ? mag - x : x - mag;
          d_dn = (mag > x_down) ? mag - x_down : x_down - mag;
          x = (d_up < d_dn) ? ratio_step(x, cur_fwd) : x_down;
        end
        mid = (x + ratio_step(x, {2'b00, cur_bwd})) >> 1;
        if (neg) begin
          if (mid > 64'(SAT_NEG)) mid = 64'(SAT_NEG);
          res.coeff_out = -mid[31:0];
        end else begin
          if (mid > 64'(SAT_POS)) mid = 64'(SAT_POS);
          res.coeff_out = mid[31:0];
        end
      end else begin
        agree_acc += (res.detected_bit == want) ? 1 : -1;
        if (agree_acc > 2047) agree_acc = 2047;
        if (agree_acc < -2048) agree_acc = -2048;
      end
      bits_taken++;
    end
    res.agree_sum = 12'(agree_acc);
    res.bits_done = bits_taken;
    res.last_out = req.last;
    expected_results.push_back(res);
    if (req.last) begin
      bits_taken = 0;
      agree_acc = 0;
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  function automatic logic [31:0] random_coeff();
    logic [31:0] v;
    int unsigned sel;
    int unsigned width;
    sel = $urandom_range(9);
    if (sel < 2) begin
      v = $urandom;
    end else if (sel < 4) begin
      v = 32'($urandom_range(66560, 64512));
    end else begin
      width = $urandom_range(31, 17);
      v = $urandom >> (32 - width);
    end
    if (sel >= 2 && $urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic push_coeff(input logic [31:0] c, input logic close);
    wm_request_t req;
    req.kind = KIND_COEFF;
    req.sig_index = 5'($urandom);
    req.sig_word = $urandom;
    req.coeff = c;
    req.last = close;
    pending_reqs.push_back(req);
  endtask

  task automatic push_sig(input logic [4:0] idx, input logic [31:0] word);
    wm_request_t req;
    req.kind = KIND_SIG;
    req.sig_index = idx;
    req.sig_word = word;
    req.coeff = $urandom;
    req.last = 1'($urandom);
    pending_reqs.push_back(req);
  endtask

  task automatic push_frame(input logic [31:0] vals[$], input logic close);
    foreach (vals[i]) push_coeff(vals[i], close && (i == vals.size() - 1));
  endtask

  task automatic settle(input int unsigned tail);
    @(negedge clk);
    while (pending_reqs.size() != 0 || coeff_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic apply_setting(input logic mode, input logic [10:0] bc,
                               input logic [17:0] fwd, input logic [15:0] bwd);
    logic [CFG_IW-1:0] reg_ids [4];
    logic [CFG_DW-1:0] reg_vals [4];
    reg_ids = '{REG_MODE, REG_BIT_COUNT, REG_FORWARD, REG_BACKWARD};
    reg_vals = '{CFG_DW'(mode), CFG_DW'(bc), fwd, CFG_DW'(bwd)};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_ids[i];
      cfg_ch.data <= reg_vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cur_mode = mode;
    cur_bit_count = bc;
    cur_fwd = fwd;
    cur_bwd = bwd;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : driver
    wm_request_t taken;
    wm_request_t nxt_req;
    if (rst) begin
      coeff_ch.valid <= 1'b0;
      reqs_taken <= 0;
    end else begin
      if (coeff_ch.valid && coeff_ch.ready) begin
        taken = '{coeff_ch.kind, coeff_ch.sig_index, coeff_ch.sig_word, coeff_ch.coeff,
                  coeff_ch.last};
        predict_request(taken);
        reqs_taken <= reqs_taken + 1;
      end
      if (!coeff_ch.valid || coeff_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt_req = pending_reqs.pop_front();
          coeff_ch.valid <= 1'b1;
          coeff_ch.kind <= nxt_req.kind;
          coeff_ch.sig_index <= nxt_req.sig_index;
          coeff_ch.sig_word <= nxt_req.sig_word;
          coeff_ch.coeff <= nxt_req.coeff;
          coeff_ch.last <= nxt_req.last;
        end else begin
          coeff_ch.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the core backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_count <= 0;
      sink_hold <= 1'b0;
      hold_done <= 1'b0;
    end else if (!hold_done && reqs_taken >= HOLD_AFTER) begin
      if (hold_count < HOLD_CYCLES) begin
        sink_hold <= 1'b1;
        hold_count <= hold_count + 1;
      end else begin
        sink_hold <= 1'b0;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    wm_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual coeff_out %h", $time,
                   out_ch.coeff_out);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("coeff_out", want.coeff_out, out_ch.coeff_out);
          check_field("bit_used", 32'(want.bit_used), 32'(out_ch.bit_used));
          check_field("detected_bit", 32'(want.detected_bit), 32'(out_ch.detected_bit));
          check_field("agree_sum", {20'd0, want.agree_sum}, {20'd0, out_ch.agree_sum});
          check_field("bits_done", 32'(want.bits_done), 32'(out_ch.bits_done));
          check_field("last_out", 32'(want.last_out), 32'(out_ch.last_out));
        end
      end
      out_ch.ready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin : stimulus
    logic [31:0] probe[$];
    int unsigned n;
    int unsigned frame_left;
    int unsigned sel;
    logic        new_mode;
    logic [10:0] new_bc;
    logic [17:0] new_fwd;
    logic [15:0] new_bwd;
    rst = 1'b1;
    coeff_ch.valid = 1'b0;
    coeff_ch.kind = KIND_SIG;
    coeff_ch.sig_index = '0;
    coeff_ch.sig_word = '0;
    coeff_ch.coeff = '0;
    coeff_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MODE;
    cfg_ch.data = '0;
    bits_taken = '0;
    agree_acc = 0;
    cur_mode = MODE_EMBED;
    cur_bit_count = '0;
    cur_fwd = FWD_RESET;
    cur_bwd = BWD_RESET;
    src_idle_pct = 33;
    snk_idle_pct = 33;
    error_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // embed at reset ratios: skip boundary, extremes and saturation
    settle(16);
    apply_setting(MODE_EMBED, 11'd1024, FWD_RESET, BWD_RESET);
    @(negedge clk);
    for (int w = 0; w < SIG_WORDS; w++) push_sig(5'(w), $urandom);
    probe = {32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0001, 32'hFFFE_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h0000_0001, 32'h0003_0000,
             32'h0123_4567};
    push_frame(probe, 1'b1);

    // detect, frame left open across the mode change
    settle(16);
    apply_setting(MODE_DETECT, 11'd1024, FWD_RESET, BWD_RESET);
    @(negedge clk);
    probe = {32'h0002_0000, 32'hFFFE_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000,
             32'h00FF_0000};
    push_frame(probe, 1'b0);

    // bits run out part way through
    settle(16);
    apply_setting(MODE_EMBED, 11'd8, FWD_RESET, BWD_RESET);
    @(negedge clk);
    probe = {32'h0004_0000, 32'hFFF0_0000, 32'h0100_0000, 32'h0004_0000};
    push_frame(probe, 1'b1);

    // smallest ratio: ladder hits the step cap
    settle(16);
    apply_setting(MODE_EMBED, 11'd2047, 18'd65537, 16'd65535);
    @(negedge clk);
    probe = {32'h7FFF_0000, 32'hFFFE_FFC0, 32'h0001_0020};
    push_frame(probe, 1'b1);

    settle(16);
    apply_setting(MODE_EMBED, 11'd5, 18'd262143, 16'd1);
    @(negedge clk);
    probe = {32'h0040_0000, 32'hFFC0_0001, 32'h7FFF_FFFF};
    push_frame(probe, 1'b1);

    for (int p = 0; p < 10; p++) begin
      settle(16);
      new_mode = (p < 2) ? p[0] : 1'($urandom_range(1));
      sel = (p < 6) ? p : $urandom_range(5);
      case (sel)
        0: new_bc = 11'd0;
        1: new_bc = 11'($urandom_range(40, 1));
        2: new_bc = 11'd1024;
        3: new_bc = 11'd2047;
        default: new_bc = 11'($urandom_range(1023, 1));
      endcase
      sel = (p < 5) ? p : $urandom_range(4);
      case (sel)
        0: new_fwd = FWD_RESET;
        1: new_fwd = 18'd65537;
        2: new_fwd = 18'd262143;
        default: new_fwd = 18'($urandom_range(262143, 65537));
      endcase
      sel = (p < 4) ? p : $urandom_range(3);
      case (sel)
        0: new_bwd = BWD_RESET;
        1: new_bwd = 16'd1;
        2: new_bwd = 16'd65535;
        default: new_bwd = 16'($urandom_range(65535, 1));
      endcase
      apply_setting(new_mode, new_bc, new_fwd, new_bwd);
      @(negedge clk);
      src_idle_pct = (p == 3) ? 0 : 33;
      snk_idle_pct = (p == 3) ? 0 : 33;
      frame_left = $urandom_range(30, 1);
      n = 0;
      while (n < PHASE_REQS) begin
        if ($urandom_range(99) < 4) begin
          push_sig(5'($urandom), $urandom);
        end else begin
          frame_left--;
          push_coeff(random_coeff(), frame_left == 0);
          if (frame_left == 0) frame_left = $urandom_range(30, 1);
        end
        n++;
      end
    end

    settle(DRAIN_CYCLES);
    @(negedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> log_step_parity_watermark_quantizer_core.f
design/lspwq_pkg.sv
design/lspwq_in_if.sv
design/lspwq_out_if.sv
design/lspwq_cfg_if.sv
design/lspwq_ram.sv
design/lspwq_dp.sv
design/lspwq_ctrl.sv
design/log_step_parity_watermark_quantizer_core.sv
design/lspwq_checker.sv
tb/tb.sv
